// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== design/flfi_pkg.sv =====
// Shared types, constants and helpers for the fuel level filter/interpolator.
// No dependencies; used by the top, flfi_alu and flfi_cfg.
package flfi_pkg;

  localparam int unsigned TABLE_POINTS_DEF = 8;
  localparam int unsigned ADC_BITS_DEF     = 12;
  localparam int unsigned FRAC_BITS_DEF    = 8;

  localparam int unsigned PT_ADC_W = 16;  // ADC level of one calibration point
  localparam int unsigned PCT_W    = 7;   // percent of one point / result
  localparam int unsigned PT_IDX_W = 3;   // index into the eight-point table
  localparam int unsigned NPTS_W   = 4;   // points_used register
  localparam int unsigned COEF_W   = 16;  // Q0.16 filter coefficients

  localparam logic [COEF_W-1:0] COEF_OLD = 16'd58982;
  localparam logic [COEF_W-1:0] COEF_NEW = 16'd6554;
  localparam logic [COEF_W-1:0] ROUND_HALF = 16'd32768;
  localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;

  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  // Register indexes (byte address / 8)
  localparam logic [2:0] REG_ADC_MAX     = 3'd0;
  localparam logic [2:0] REG_POINTS_USED = 3'd1;
  localparam logic [2:0] REG_PT_ADC_LO   = 3'd2;
  localparam logic [2:0] REG_PT_ADC_HI   = 3'd3;
  localparam logic [2:0] REG_PT_PCT      = 3'd4;

  localparam logic [15:0] ADC_MAX_RST = 16'd4095;

  typedef struct packed {
    logic [15:0] adc_max;
    logic [3:0]  points_used;
    logic [63:0] pt_adc_lo;
    logic [63:0] pt_adc_hi;
    logic [55:0] pt_pct;
  } cfg_t;

  typedef enum logic {
    ALU_MAC,
    ALU_SUB
  } alu_op_e;

  function automatic logic [PT_ADC_W-1:0] point_adc(cfg_t c, logic [PT_IDX_W-1:0] i);
    logic [63:0] w;
    w = i[2] ? c.pt_adc_hi : c.pt_adc_lo;
    return w[PT_ADC_W*i[1:0] +: PT_ADC_W];
  endfunction

  function automatic logic [PCT_W-1:0] point_pct(cfg_t c, logic [PT_IDX_W-1:0] i);
    return c.pt_pct[PCT_W*i +: PCT_W];
  endfunction

  function automatic logic [PCT_W-1:0] clamp_pct(logic [PCT_W-1:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

// ===== design/fuel_level_filter_interpolator_unit.sv =====
// Fuel level filter and calibration-table interpolator, top level.
// Depends on flfi_pkg, flfi_alu and flfi_cfg.
//
// Each input beat carries one raw fuel-sender sample. The sample is clamped
// to adc_max, smoothed by an exponential average (0.9 old + 0.1 new, Q0.16
// coefficients, rounded; the first sample after reset loads the filter) and
// the smoothed level is mapped through a calibration table of up to eight
// (level, percent) points. The first segment that brackets the level is
// interpolated and rounded half up; a zero-span segment gives its first
// percent; outside the table the nearer end point wins, ties to the last.
// Percent is clamped to 100; fewer than two points give 0. One result beat
// per input beat. The block works on one sample at a time and s_axis_tready
// is low while it does. The work runs on the single shared
// multiply-accumulate/subtract unit (two filter passes, one subtraction,
// two products, one add; the sample that loads the filter skips the filter
// passes) and the seven-step restoring divide that rounds the percent. A
// result waits in the output register while the next sample is accepted;
// the block only stalls at its end if that register is still full.
// Configuration is an APB slave with 64-bit registers at byte address 8*i;
// pready is tied high.
module fuel_level_filter_interpolator_unit #(
  parameter int unsigned TABLE_POINTS = flfi_pkg::TABLE_POINTS_DEF,
  parameter int unsigned ADC_BITS     = flfi_pkg::ADC_BITS_DEF,
  parameter int unsigned FRAC_BITS    = flfi_pkg::FRAC_BITS_DEF,
  localparam int unsigned LW    = ADC_BITS + FRAC_BITS,
  localparam int unsigned IN_W  = ((ADC_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((flfi_pkg::PCT_W + LW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,  // raw_sample
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata,  // fill_percent, smoothed_level
  output logic                          m_axis_tuser,  // inside_table
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flfi_pkg::APB_AW-1:0]   paddr,
  input  logic [flfi_pkg::APB_DW-1:0]   pwdata,
  output logic [flfi_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned PW  = flfi_pkg::PT_ADC_W + FRAC_BITS;  // point level width
  localparam int unsigned RW  = PW + flfi_pkg::COEF_W + 1;      // accumulator width
  localparam int unsigned IW  = $clog2(TABLE_POINTS);
  localparam int unsigned PCW = flfi_pkg::PCT_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_FILT0   = 4'd1;
  localparam logic [3:0] ST_FILT1   = 4'd2;
  localparam logic [3:0] ST_SEARCH  = 4'd3;
  localparam logic [3:0] ST_SEGD    = 4'd4;
  localparam logic [3:0] ST_SUB     = 4'd5;
  localparam logic [3:0] ST_MUL1    = 4'd6;
  localparam logic [3:0] ST_MUL2    = 4'd7;
  localparam logic [3:0] ST_PREP    = 4'd8;
  localparam logic [3:0] ST_DIV     = 4'd9;
  localparam logic [3:0] ST_OUTSIDE = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  flfi_pkg::cfg_t cfg;

  flfi_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  // registers
  logic [3:0]          state_q, state_d;
  logic [ADC_BITS-1:0] sample_q, sample_d;
  logic [LW-1:0]       level_q, level_d;
  logic                primed_q, primed_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [RW-1:0]       acc_q, acc_d;
  logic [RW-1:0]       dv_q, dv_d;
  logic [PW-1:0]       d_q, d_d;
  logic [PW-1:0]       den_q, den_d;
  logic [PCW-1:0]      p1_q, p1_d;
  logic [PCW-1:0]      p2_q, p2_d;
  logic [PCW-1:0]      quo_q, quo_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [PCW-1:0]      pct_q, pct_d;
  logic                inside_q, inside_d;
  logic                ovalid_q, ovalid_d;
  logic [PCW-1:0]      opct_q, opct_d;
  logic [LW-1:0]       olevel_q, olevel_d;
  logic                oinside_q, oinside_d;

  // shared unit
  flfi_pkg::alu_op_e            alu_op;
  logic [RW-1:0]                alu_a, alu_c, alu_res;
  logic [flfi_pkg::COEF_W-1:0]  alu_b;
  logic                         alu_borrow;

  flfi_alu #(
    .PW (PW),
    .RW (RW)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .c_i      (alu_c),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // table access
  logic [ADC_BITS-1:0]          raw;
  logic [flfi_pkg::NPTS_W-1:0]  n_pts;
  logic [flfi_pkg::PT_IDX_W-1:0] i0, i1, last_i;
  logic [PW-1:0]                lvl, a1, a2, pf, pl, df, dl;
  logic                         in_seg, seg_last;
  logic                         out_take;
  logic [PCW-1:0]               quo_nx;

  assign raw    = s_axis_tdata[ADC_BITS-1:0];
  assign n_pts  = (cfg.points_used > flfi_pkg::NPTS_W'(TABLE_POINTS)) ?
                  flfi_pkg::NPTS_W'(TABLE_POINTS) : cfg.points_used;
  assign i0     = flfi_pkg::PT_IDX_W'(idx_q);
  assign i1     = i0 + 3'd1;
  assign last_i = flfi_pkg::PT_IDX_W'(n_pts - 4'd1);
  assign lvl    = PW'(level_q);
  assign a1     = {flfi_pkg::point_adc(cfg, i0), {FRAC_BITS{1'b0}}};
  assign a2     = {flfi_pkg::point_adc(cfg, i1), {FRAC_BITS{1'b0}}};
  assign pf     = {flfi_pkg::point_adc(cfg, 3'd0), {FRAC_BITS{1'b0}}};
  assign pl     = {flfi_pkg::point_adc(cfg, last_i), {FRAC_BITS{1'b0}}};
  assign df     = (lvl > pf) ? (lvl - pf) : (pf - lvl);
  assign dl     = (lvl > pl) ? (lvl - pl) : (pl - lvl);
  assign in_seg = ((lvl >= a1) && (lvl <= a2)) || ((lvl <= a1) && (lvl >= a2));
  assign seg_last = (flfi_pkg::NPTS_W'(idx_q) + 4'd2) >= n_pts;
  assign out_take = ovalid_q && m_axis_tready;
  assign quo_nx   = {quo_q[PCW-2:0], !alu_borrow};

  always_comb begin
    state_d   = state_q;
    sample_d  = sample_q;
    level_d   = level_q;
    primed_d  = primed_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    dv_d      = dv_q;
    d_d       = d_q;
    den_d     = den_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    pct_d     = pct_q;
    inside_d  = inside_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    opct_d    = opct_q;
    olevel_d  = olevel_q;
    oinside_d = oinside_q;

    alu_op = flfi_pkg::ALU_MAC;
    alu_a  = '0;
    alu_b  = '0;
    alu_c  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          // clamp to adc_max; a larger limit than the sample range never bites
          if (ADC_BITS'(cfg.adc_max) < raw &&
              cfg.adc_max < flfi_pkg::PT_ADC_W'(raw) + 16'd1) begin
            sample_d = ADC_BITS'(cfg.adc_max);
          end else begin
            sample_d = raw;
          end
          if (flfi_pkg::PT_ADC_W'(raw) > cfg.adc_max) begin
            sample_d = ADC_BITS'(cfg.adc_max);
          end
          idx_d   = '0;
          state_d = ST_FILT0;
        end
      end
      ST_FILT0: begin
        if (!primed_q) begin
          level_d  = {sample_q, {FRAC_BITS{1'b0}}};
          primed_d = 1'b1;
          state_d  = ST_SEARCH;
        end else begin
          alu_op  = flfi_pkg::ALU_MAC;
          alu_a   = RW'(level_q);
          alu_b   = flfi_pkg::COEF_OLD;
          alu_c   = RW'(flfi_pkg::ROUND_HALF);
          acc_d   = alu_res;
          state_d = ST_FILT1;
        end
      end
      ST_FILT1: begin
        alu_op  = flfi_pkg::ALU_MAC;
        alu_a   = RW'({sample_q, {FRAC_BITS{1'b0}}});
        alu_b   = flfi_pkg::COEF_NEW;
        alu_c   = acc_q;
        level_d = alu_res[flfi_pkg::COEF_W +: LW];
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (n_pts < 4'd2) begin
          pct_d    = '0;
          inside_d = 1'b0;
          state_d  = ST_DONE;
        end else if (in_seg) begin
          p1_d     = flfi_pkg::point_pct(cfg, i0);
          p2_d     = flfi_pkg::point_pct(cfg, i1);
          inside_d = 1'b1;
          if (a1 == a2) begin
            pct_d   = flfi_pkg::clamp_pct(flfi_pkg::point_pct(cfg, i0));
            state_d = ST_DONE;
          end else begin
            state_d = ST_SEGD;
          end
        end else if (seg_last) begin
          state_d = ST_OUTSIDE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_SEGD: begin
        // distances from the first point; result is p1*(den-d) + p2*d over den
        d_d     = (lvl > a1) ? (lvl - a1) : (a1 - lvl);
        den_d   = (a2 > a1) ? (a2 - a1) : (a1 - a2);
        state_d = ST_SUB;
      end
      ST_SUB: begin
        alu_op  = flfi_pkg::ALU_SUB;
        alu_a   = RW'(den_q);
        alu_c   = RW'(d_q);
        acc_d   = alu_res;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        alu_op  = flfi_pkg::ALU_MAC;
        alu_a   = acc_q;
        alu_b   = flfi_pkg::COEF_W'(p1_q);
        alu_c   = '0;
        acc_d   = alu_res;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        alu_op  = flfi_pkg::ALU_MAC;
        alu_a   = RW'(d_q);
        alu_b   = flfi_pkg::COEF_W'(p2_q);
        alu_c   = acc_q;
        acc_d   = alu_res;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        // rounding numerator 2*tot + den, divisor 2*den aligned to quotient bit 6
        alu_op  = flfi_pkg::ALU_MAC;
        alu_a   = RW'(den_q);
        alu_b   = flfi_pkg::COEF_W'(1);
        alu_c   = {acc_q[RW-2:0], 1'b0};
        acc_d   = alu_res;
        dv_d    = RW'(den_q) << PCW;
        quo_d   = '0;
        cnt_d   = 3'(PCW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        alu_op = flfi_pkg::ALU_SUB;
        alu_a  = acc_q;
        alu_c  = dv_q;
        if (!alu_borrow) begin
          acc_d = alu_res;
        end
        quo_d = quo_nx;
        dv_d  = dv_q >> 1;
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          pct_d   = flfi_pkg::clamp_pct(quo_nx);
          state_d = ST_DONE;
        end
      end
      ST_OUTSIDE: begin
        // strictly nearer to point 0 picks it, a tie goes to the last point
        pct_d    = flfi_pkg::clamp_pct((df < dl) ? flfi_pkg::point_pct(cfg, 3'd0) :
                                                   flfi_pkg::point_pct(cfg, last_i));
        inside_d = 1'b0;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_q || out_take) begin
          ovalid_d  = 1'b1;
          opct_d    = pct_q;
          olevel_d  = level_q;
          oinside_d = inside_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      level_q  <= '0;
      primed_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      level_q  <= level_d;
      primed_q <= primed_d;
      ovalid_q <= ovalid_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    idx_q     <= idx_d;
    acc_q     <= acc_d;
    dv_q      <= dv_d;
    d_q       <= d_d;
    den_q     <= den_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    pct_q     <= pct_d;
    inside_q  <= inside_d;
    opct_q    <= opct_d;
    olevel_q  <= olevel_d;
    oinside_q <= oinside_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_W'({olevel_q, opct_q});
  assign m_axis_tuser  = oinside_q;

endmodule

// ===== design/flfi_alu.sv =====
// Shared arithmetic unit: multiply-accumulate or subtract with borrow.
// Depends on flfi_pkg for the operation code and coefficient width.
module flfi_alu #(
  parameter int unsigned PW = 24,
  parameter int unsigned RW = 41
) (
  input  flfi_pkg::alu_op_e             op_i,
  input  logic [RW-1:0]                 a_i,
  input  logic [flfi_pkg::COEF_W-1:0]   b_i,
  input  logic [RW-1:0]                 c_i,
  output logic [RW-1:0]                 res_o,
  output logic                          borrow_o
);

  logic [PW+flfi_pkg::COEF_W-1:0] prod;

  assign prod = a_i[PW-1:0] * b_i;

  always_comb begin
    unique case (op_i)
      flfi_pkg::ALU_MAC: begin
        res_o    = c_i + RW'(prod);
        borrow_o = 1'b0;
      end
      flfi_pkg::ALU_SUB: begin
        res_o    = a_i - c_i;
        borrow_o = (a_i < c_i);
      end
      default: begin
        res_o    = '0;
        borrow_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/flfi_cfg.sv =====
// APB register file: adc_max, points_used, point levels and point percents.
// Depends on flfi_pkg for cfg_t, register indexes and bus widths.
module flfi_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [flfi_pkg::APB_AW-1:0]   paddr_i,
  input  logic [flfi_pkg::APB_DW-1:0]   pwdata_i,
  output logic [flfi_pkg::APB_DW-1:0]   prdata_o,
  output flfi_pkg::cfg_t                cfg_o
);

  flfi_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr;

  assign idx = paddr_i[5:3];
  assign wr  = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_max     <= flfi_pkg::ADC_MAX_RST;
      cfg_q.points_used <= '0;
      cfg_q.pt_adc_lo   <= '0;
      cfg_q.pt_adc_hi   <= '0;
      cfg_q.pt_pct      <= '0;
    end else if (wr) begin
      unique case (idx)
        flfi_pkg::REG_ADC_MAX:     cfg_q.adc_max     <= pwdata_i[15:0];
        flfi_pkg::REG_POINTS_USED: cfg_q.points_used <= pwdata_i[3:0];
        flfi_pkg::REG_PT_ADC_LO:   cfg_q.pt_adc_lo   <= pwdata_i;
        flfi_pkg::REG_PT_ADC_HI:   cfg_q.pt_adc_hi   <= pwdata_i;
        flfi_pkg::REG_PT_PCT:      cfg_q.pt_pct      <= pwdata_i[55:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      flfi_pkg::REG_ADC_MAX:     prdata_o = {48'd0, cfg_q.adc_max};
      flfi_pkg::REG_POINTS_USED: prdata_o = {60'd0, cfg_q.points_used};
      flfi_pkg::REG_PT_ADC_LO:   prdata_o = cfg_q.pt_adc_lo;
      flfi_pkg::REG_PT_ADC_HI:   prdata_o = cfg_q.pt_adc_hi;
      flfi_pkg::REG_PT_PCT:      prdata_o = {8'd0, cfg_q.pt_pct};
      default:                   prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/flfi_checker.sv =====
// Port-level checks for the fuel level filter/interpolator, bound to the top.
// Depends on assert_macros.svh and fuel_level_filter_interpolator_unit.
`include "assert_macros.svh"

module flfi_checker #(
  parameter int unsigned OUT_W = 32
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // held result beat keeps its payload
  `ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // percent never above 100
  `ASSERT_IMP(a_pct_range, m_axis_tvalid, m_axis_tdata[6:0] <= 7'd100)
  // the sequencer is busy right after taking a sample
  `ASSERT_NXT(a_busy_after_in, in_beat, !s_axis_tready)
  // a new result appears only as the sequencer finishes an item
  `ASSERT_IMP(a_result_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind fuel_level_filter_interpolator_unit flfi_checker #(
  .OUT_W (OUT_W)
) u_flfi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
